// ===== hdl/iba_pkg.sv =====
// ----------------------------------------------------------------------------
// iba_pkg
// Shared codes and controller/datapath handshake types for the indexed
// block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package iba_pkg;

  // Operation codes carried on the request word.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EXISTS    = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_NO_SLOT   = 3'd3;
  localparam logic [2:0] ST_NO_SPACE  = 3'd4;

  // One request never yields more result words than this.
  localparam int unsigned RESULT_LIMIT = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;    // latch the accepted request word
    logic       start_ins;  // reserve the open slot and charge the free count
    logic       start_del;  // select the matching slot for release
    logic       scan_adv;   // step past a used block
    logic       claim;      // take the block under the scan pointer
    logic       del_free;   // release the block read from the list
    logic       del_fin;    // drop the slot and post the delete result
    logic       reject;     // post a single error result
    logic [2:0] rej_code;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic op_delete;
    logic key_hit;
    logic slot_open;
    logic count_bad;
    logic blk_free;
    logic alloc_last;
    logic del_last;
    logic out_room;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/iba_req_if.sv =====
// ----------------------------------------------------------------------------
// iba_req_if
// Request channel: one word is one insert or delete command.
// ----------------------------------------------------------------------------
`default_nettype none

interface iba_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] file_key;
  logic [5:0]  block_count;

  modport source (output valid, output operation, output file_key,
                  output block_count, input ready);
  modport sink   (input valid, input operation, input file_key,
                  input block_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/iba_rsp_if.sv =====
// ----------------------------------------------------------------------------
// iba_rsp_if
// Result channel: one word per claimed block, or one word per command.
// ----------------------------------------------------------------------------
`default_nettype none

interface iba_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [4:0] block_index;
  logic [4:0] first_block;
  logic [5:0] free_count;
  logic       last;

  modport source (output valid, output status, output block_index,
                  output first_block, output free_count, output last,
                  input ready);
  modport sink   (input valid, input status, input block_index,
                  input first_block, input free_count, input last,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/iba_ctrl.sv =====
// ----------------------------------------------------------------------------
// iba_ctrl
// Sequencer for one command at a time: lookup, block scan or block release.
// ----------------------------------------------------------------------------
`default_nettype none

module iba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire iba_pkg::sts_t sts,
  output iba_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_ALLOC,
    S_DEL_RD,
    S_DEL_FREE,
    S_DEL_FIN
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (sts.op_delete) begin
          if (!sts.key_hit) begin
            if (sts.out_room) begin
              cmd.reject   = 1'b1;
              cmd.rej_code = iba_pkg::ST_NOT_FOUND;
              state_next   = S_IDLE;
            end
          end else begin
            cmd.start_del = 1'b1;
            state_next    = S_DEL_RD;
          end
        end else if (sts.key_hit || !sts.slot_open || sts.count_bad) begin
          // Error precedence: duplicate key, then table full, then space.
          if (sts.out_room) begin
            cmd.reject = 1'b1;
            if (sts.key_hit) begin
              cmd.rej_code = iba_pkg::ST_EXISTS;
            end else if (!sts.slot_open) begin
              cmd.rej_code = iba_pkg::ST_NO_SLOT;
            end else begin
              cmd.rej_code = iba_pkg::ST_NO_SPACE;
            end
            state_next = S_IDLE;
          end
        end else begin
          cmd.start_ins = 1'b1;
          state_next    = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (!sts.blk_free) begin
          cmd.scan_adv = 1'b1;
        end else if (sts.out_room) begin
          cmd.claim = 1'b1;
          if (sts.alloc_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_DEL_RD: begin
        state_next = S_DEL_FREE;
      end
      S_DEL_FREE: begin
        cmd.del_free = 1'b1;
        state_next   = sts.del_last ? S_DEL_FIN : S_DEL_RD;
      end
      S_DEL_FIN: begin
        if (sts.out_room) begin
          cmd.del_fin = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/iba_dp.sv =====
// ----------------------------------------------------------------------------
// iba_dp
// Bitmap, file table, block list memory and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module iba_dp #(
  parameter int NUM_BLOCKS = 32,
  parameter int FILE_SLOTS = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_operation,
  input  wire logic [15:0]   req_file_key,
  input  wire logic [5:0]    req_block_count,
  input  wire iba_pkg::cmd_t cmd,
  output iba_pkg::sts_t      sts,
  iba_rsp_if.source          rsp
);

  localparam int BW    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CW    = $clog2(NUM_BLOCKS + 1);
  localparam int SW    = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
  localparam int DEPTH = FILE_SLOTS * NUM_BLOCKS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Latched request.
  logic        op_q;
  logic [15:0] key_q;
  logic [5:0]  count_q;

  // Allocation state.
  logic [NUM_BLOCKS-1:0] map;
  logic [CW-1:0]         free_blocks;
  logic [FILE_SLOTS-1:0] slot_valid;
  logic [15:0]           slot_key    [FILE_SLOTS];
  logic [BW-1:0]         slot_first  [FILE_SLOTS];
  logic [CW-1:0]         slot_length [FILE_SLOTS];
  logic [BW-1:0]         mem         [DEPTH];
  logic [BW-1:0]         rdata;

  // Working registers for the current command.
  logic [SW-1:0] slot_q;
  logic [AW-1:0] base_q;
  logic [BW-1:0] ptr;
  logic [CW-1:0] idx;
  logic [BW-1:0] first_q;

  logic          hit;
  logic [SW-1:0] hit_idx;
  logic          open;
  logic [SW-1:0] open_idx;
  logic [SW-1:0] sel_slot;
  logic [AW-1:0] base_next;
  logic [AW-1:0] mem_addr;
  logic          rd_valid;
  logic          load;

  // Slot table search; the descending loop leaves the lowest match.
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    open     = 1'b0;
    open_idx = '0;
    for (int s = FILE_SLOTS - 1; s >= 0; s--) begin
      if (slot_valid[s] && (slot_key[s] == key_q)) begin
        hit     = 1'b1;
        hit_idx = SW'(s);
      end
      if (!slot_valid[s]) begin
        open     = 1'b1;
        open_idx = SW'(s);
      end
    end
  end

  assign sel_slot  = (op_q == iba_pkg::OP_DELETE) ? hit_idx : open_idx;
  assign base_next = AW'(AW'(sel_slot) * AW'(NUM_BLOCKS));
  assign mem_addr  = base_q + AW'(idx);
  assign rd_valid  = (8'(rdata) < 8'(NUM_BLOCKS));
  assign load      = cmd.claim | cmd.del_fin | cmd.reject;

  always_comb begin
    sts.op_delete  = (op_q == iba_pkg::OP_DELETE);
    sts.key_hit    = hit;
    sts.slot_open  = open;
    sts.count_bad  = (count_q == '0)
                   || (8'(count_q) > 8'(free_blocks))
                   || (8'(count_q) > 8'(iba_pkg::RESULT_LIMIT));
    sts.blk_free   = !map[ptr];
    sts.alloc_last = ((8'(idx) + 8'd1) == 8'(count_q));
    sts.del_last   = ((8'(idx) + 8'd1) == 8'(slot_length[slot_q]));
    sts.out_room   = !rsp.valid || rsp.ready;
  end

  // Block list memory: written as blocks are claimed, read on release.
  always_ff @(posedge clk) begin
    if (cmd.claim) begin
      mem[mem_addr] <= ptr;
    end
    rdata <= mem[mem_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      map         <= '0;
      free_blocks <= CW'(NUM_BLOCKS);
      slot_valid  <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      if (cmd.start_ins) begin
        slot_valid[open_idx] <= 1'b1;
        free_blocks          <= free_blocks - CW'(count_q);
      end
      if (cmd.claim) begin
        map[ptr] <= 1'b1;
      end
      if (cmd.del_free && rd_valid && map[rdata]) begin
        map[rdata]  <= 1'b0;
        free_blocks <= free_blocks + CW'(1);
      end
      if (cmd.del_fin) begin
        slot_valid[slot_q] <= 1'b0;
      end
      if (load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= req_operation;
      key_q   <= req_file_key;
      count_q <= req_block_count;
    end
    if (cmd.start_ins || cmd.start_del) begin
      slot_q <= sel_slot;
      base_q <= base_next;
      ptr    <= '0;
      idx    <= '0;
    end
    if (cmd.start_ins) begin
      slot_key[open_idx]    <= key_q;
      slot_length[open_idx] <= CW'(count_q);
    end
    if (cmd.scan_adv) begin
      ptr <= ptr + BW'(1);
    end
    if (cmd.claim) begin
      ptr <= ptr + BW'(1);
      idx <= idx + CW'(1);
      if (idx == '0) begin
        first_q            <= ptr;
        slot_first[slot_q] <= ptr;
      end
      rsp.status      <= iba_pkg::ST_OK;
      rsp.block_index <= 5'(ptr);
      rsp.first_block <= (idx == '0) ? 5'(ptr) : 5'(first_q);
      rsp.free_count  <= 6'(free_blocks);
      rsp.last        <= sts.alloc_last;
    end
    if (cmd.del_free) begin
      idx <= idx + CW'(1);
    end
    if (cmd.del_fin) begin
      rsp.status      <= iba_pkg::ST_OK;
      rsp.block_index <= '0;
      rsp.first_block <= 5'(slot_first[slot_q]);
      rsp.free_count  <= 6'(free_blocks);
      rsp.last        <= 1'b1;
    end
    if (cmd.reject) begin
      rsp.status      <= cmd.rej_code;
      rsp.block_index <= '0;
      rsp.first_block <= '0;
      rsp.free_count  <= 6'(free_blocks);
      rsp.last        <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/indexed_block_allocator_core.sv =====
// A rejected command loads its single result word from the lookup state once the output has room.
// Insert: one bitmap bit is tested per cycle, holding on a free block while the output is full.
// Delete: each release passes a read state then a free state, waiting on the list memory read.
// One command at a time; the next is taken once the controller is back in idle after its
// last word is loaded; output stalls delay it further.
// Reset (rst, synchronous, active high) frees every block and empties the file table.
// ----------------------------------------------------------------------------
// indexed_block_allocator_core
// Free-block bitmap allocator with a small indexed file table.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_block_allocator_core #(
  parameter int NUM_BLOCKS = 32,
  parameter int FILE_SLOTS = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  iba_req_if.sink   req,
  iba_rsp_if.source rsp
);

  // The controller sequences each command; the datapath owns all storage.
  // A request word is taken only while the controller is idle. The result
  // register sits in the datapath, so a new request can be accepted while
  // the final result word of the previous command still waits downstream.

  iba_pkg::cmd_t cmd;
  iba_pkg::sts_t sts;
  logic          ctrl_ready;

  assign req.ready = ctrl_ready;

  iba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ctrl_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // An insert claims the lowest free blocks one at a time, writing each one
  // into the slot's block list and emitting a result word per block. A
  // delete reads the slot's list back and clears each listed block.
  iba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .FILE_SLOTS (FILE_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .req_operation   (req.operation),
    .req_file_key    (req.file_key),
    .req_block_count (req.block_count),
    .cmd             (cmd),
    .sts             (sts),
    .rsp             (rsp)
  );

endmodule

`default_nettype wire
